### rtl/whp_pkg.sv
package whp_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_REPORT = 2'd3
  } action_t;

  typedef enum logic {
    STEP_PCT = 1'b0,
    STEP_DIV = 1'b1
  } step_op_t;

  localparam int BOUND_COUNT = 7;
  localparam logic [13:0] BUCKET_BOUND [BOUND_COUNT] = '{
    14'd0, 14'd300, 14'd600, 14'd1200, 14'd2500, 14'd5000, 14'd7500
  };

  localparam logic [13:0] PERCENT_FULL = 14'd10000;
  localparam logic [13:0] HALF_BIN     = 14'd50;
  localparam logic [13:0] BIN_RECIP    = 14'd5243;
  localparam int          BIN_SHIFT    = 19;

  localparam logic [9:0] PERMILLE_FULL  = 10'd1000;
  localparam logic [9:0] PERMILLE_RESET = 10'd950;
  localparam int         PCT_SCALE      = 1000;

  localparam int         SHARE_W    = 14;
  localparam int         DSTEP_W    = 4;
  localparam logic [3:0] DSTEP_LAST = 4'd13;

  localparam logic REG_PERCENTILE = 1'b0;

endpackage

### rtl/whp_step_unit.sv
module whp_step_unit #(
  parameter int CW = 32
) (
  input  whp_pkg::step_op_t op,
  input  logic [CW-1:0]     skipped,
  input  logic [CW+9:0]     need,
  input  logic [CW-1:0]     rem,
  input  logic              shift_bit,
  input  logic [CW-1:0]     divisor,
  output logic              ge,
  output logic [CW-1:0]     rem_next
);

  localparam int W = CW + 10;

  logic [W-1:0]  scaled;
  logic [CW:0]   shifted;
  logic [W:0]    opa;
  logic [W:0]    opb;
  logic [W:0]    diff;

  always_comb begin
    scaled  = W'(skipped) * W'(whp_pkg::PCT_SCALE);
    shifted = {rem, shift_bit};
    unique case (op)
      whp_pkg::STEP_PCT: begin
        opa = {1'b0, scaled};
        opb = {1'b0, need};
      end
      whp_pkg::STEP_DIV: begin
        opa = (W+1)'(shifted);
        opb = (W+1)'(divisor);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    diff     = opa - opb;
    ge       = ~diff[W];
    rem_next = ge ? diff[CW-1:0] : shifted[CW-1:0];
  end

endmodule

### rtl/weighted_histogram_percentile_core.sv
// Channel   Handshake                          Payload
// config    psel/penable/pwrite/pready (APB)   paddr, pwdata, prdata
// command   start, accepted when busy is low   action, percent_hundredths, weight
// result    result_strobe, one cycle           percentile_bin, bucket_index,
//                                              bucket_share, last
//
// Add: bin memory read, then write back. Clear: taken as the command is accepted, with no busy state.
// Percentile query: a multiply state, then compare and accumulate states per bin stepped past,
// paced by the single bin memory read port feeding the shared compare unit; only the multiply
// state when empty. Bucket report: per bucket a multiply state, then one quotient bit per step
// through the shared subtract unit; only the multiply state per bucket when empty.
// Reset is synchronous and clears all counts at once; no clearing pass.
// Results cannot be stalled; each is shown for exactly one cycle.
module weighted_histogram_percentile_core #(
  parameter int NUM_BINS    = 101,
  parameter int NUM_BUCKETS = 7,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [13:0] percent_hundredths,
  input  logic [15:0] weight,
  output logic        result_strobe,
  output logic [6:0]  percentile_bin,
  output logic [2:0]  bucket_index,
  output logic [13:0] bucket_share,
  output logic        last
);

  localparam int CW      = COUNT_WIDTH;
  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int NB_USED = (NUM_BUCKETS < whp_pkg::BOUND_COUNT) ? NUM_BUCKETS
                                                                : whp_pkg::BOUND_COUNT;
  localparam int NEED_W  = CW + 10;
  localparam int SW      = whp_pkg::SHARE_W;
  localparam int PROD_W  = CW + SW;
  localparam logic [CW-1:0]    COUNT_MAX = '1;
  localparam logic [BIN_W-1:0] TOP_BIN   = BIN_W'(NUM_BINS - 1);
  localparam logic [BKT_W-1:0] LAST_BKT  = BKT_W'(NUM_BUCKETS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ADD_WR = 7'b0000010,
    S_PQ_MUL = 7'b0000100,
    S_PQ_CMP = 7'b0001000,
    S_PQ_ACC = 7'b0010000,
    S_BR_MUL = 7'b0100000,
    S_BR_DIV = 7'b1000000
  } state_t;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CW] ? COUNT_MAX : sum[CW-1:0];
  endfunction

  state_t state;
  state_t state_next;

  logic [9:0]             pm;
  logic [CW-1:0]          total;
  logic [CW-1:0]          buckets [NUM_BUCKETS];
  logic [NUM_BINS-1:0]    bin_valid;
  logic [CW-1:0]          mem [NUM_BINS];
  logic [CW-1:0]          rdata;
  logic                   rvalid;

  logic [BIN_W-1:0]       add_bin;
  logic [BKT_W-1:0]       add_bkt;
  logic [15:0]            add_w;
  logic [BIN_W-1:0]       idx;
  logic [CW-1:0]          skipped;
  logic [NEED_W-1:0]      need;
  logic [CW-1:0]          rem;
  logic [SW-1:0]          num_lo;
  logic [SW-1:0]          quot;
  logic [whp_pkg::DSTEP_W-1:0] dstep;
  logic [BKT_W-1:0]       k;

  logic                   accept;
  logic [13:0]            p_clamp;
  logic [13:0]            bin_sum;
  logic [27:0]            bin_prod;
  logic [6:0]             bin_raw;
  logic [BIN_W-1:0]       in_bin;
  logic [BKT_W-1:0]       in_bkt;
  logic [BIN_W-1:0]       raddr;
  logic [CW-1:0]          rd_eff;
  logic [CW-1:0]          mem_wdata;
  logic                   mem_we;
  logic [BKT_W-1:0]       bkt_sel;
  logic [CW-1:0]          bkt_cur;
  logic [PROD_W-1:0]      bkt_prod;
  logic [9:0]             pm_eff;
  logic [9:0]             pm_gap;
  logic                   total_zero;
  logic                   pct_empty;
  logic                   pct_done;
  logic                   bkt_empty;
  logic                   div_done;
  logic                   bkt_last;
  logic                   cfg_wr;
  whp_pkg::step_op_t      step_op;
  logic                   step_ge;
  logic [CW-1:0]          step_rem;

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == whp_pkg::REG_PERCENTILE);

  always_comb begin
    prdata = (paddr[2] == whp_pkg::REG_PERCENTILE) ? 32'(pm) : '0;
  end

  always_comb begin
    p_clamp  = (percent_hundredths > whp_pkg::PERCENT_FULL) ? whp_pkg::PERCENT_FULL
                                                            : percent_hundredths;
    bin_sum  = p_clamp + whp_pkg::HALF_BIN;
    bin_prod = 28'(bin_sum) * 28'(whp_pkg::BIN_RECIP);
    bin_raw  = 7'(bin_prod >> whp_pkg::BIN_SHIFT);
    if (32'(bin_raw) > NUM_BINS - 1) begin
      in_bin = TOP_BIN;
    end else begin
      in_bin = BIN_W'(bin_raw);
    end
    in_bkt = '0;
    for (int i = 1; i < NB_USED; i++) begin
      if (p_clamp >= whp_pkg::BUCKET_BOUND[i]) begin
        in_bkt = BKT_W'(i);
      end
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:   raddr = (action == whp_pkg::ACT_ADD) ? in_bin : TOP_BIN;
      S_PQ_CMP: raddr = idx - 1'b1;
      default:  raddr = '0;
    endcase
    rd_eff     = rvalid ? rdata : '0;
    mem_we     = (state == S_ADD_WR);
    mem_wdata  = sat_add(rd_eff, CW'(add_w));
    bkt_sel    = (state == S_ADD_WR) ? add_bkt : k;
    bkt_cur    = buckets[bkt_sel];
    bkt_prod   = PROD_W'(bkt_cur) * PROD_W'(whp_pkg::PERCENT_FULL);
    pm_eff     = (pm > whp_pkg::PERMILLE_FULL) ? whp_pkg::PERMILLE_FULL : pm;
    pm_gap     = whp_pkg::PERMILLE_FULL - pm_eff;
    total_zero = (total == '0);
    step_op    = (state == S_BR_DIV) ? whp_pkg::STEP_DIV : whp_pkg::STEP_PCT;
    pct_empty  = (state == S_PQ_MUL) && total_zero;
    pct_done   = (state == S_PQ_CMP) && (step_ge || idx == '0);
    bkt_empty  = (state == S_BR_MUL) && total_zero;
    div_done   = (state == S_BR_DIV) && (dstep == whp_pkg::DSTEP_LAST);
    bkt_last   = (k == LAST_BKT);
  end

  whp_step_unit #(
    .CW (CW)
  ) u_step (
    .op        (step_op),
    .skipped   (skipped),
    .need      (need),
    .rem       (rem),
    .shift_bit (num_lo[SW-1]),
    .divisor   (total),
    .ge        (step_ge),
    .rem_next  (step_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (whp_pkg::action_t'(action))
            whp_pkg::ACT_ADD:    state_next = S_ADD_WR;
            whp_pkg::ACT_QUERY:  state_next = S_PQ_MUL;
            whp_pkg::ACT_REPORT: state_next = S_BR_MUL;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_WR: state_next = S_IDLE;
      S_PQ_MUL: state_next = total_zero ? S_IDLE : S_PQ_CMP;
      S_PQ_CMP: state_next = pct_done ? S_IDLE : S_PQ_ACC;
      S_PQ_ACC: state_next = S_PQ_CMP;
      S_BR_MUL: begin
        if (!total_zero) begin
          state_next = S_BR_DIV;
        end else if (bkt_last) begin
          state_next = S_IDLE;
        end
      end
      S_BR_DIV: begin
        if (div_done) begin
          state_next = bkt_last ? S_IDLE : S_BR_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pm            <= whp_pkg::PERMILLE_RESET;
      total         <= '0;
      bin_valid     <= '0;
      result_strobe <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        buckets[i] <= '0;
      end
    end else begin
      state         <= state_next;
      result_strobe <= pct_empty || pct_done || bkt_empty || div_done;
      if (cfg_wr) begin
        pm <= pwdata[9:0];
      end
      if (accept && action == whp_pkg::ACT_CLEAR) begin
        total     <= '0;
        bin_valid <= '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          buckets[i] <= '0;
        end
      end
      if (state == S_ADD_WR) begin
        bin_valid[add_bin] <= 1'b1;
        buckets[add_bkt]   <= sat_add(bkt_cur, CW'(add_w));
        total              <= sat_add(total, CW'(add_w));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[add_bin] <= mem_wdata;
    end
    rdata  <= mem[raddr];
    rvalid <= bin_valid[raddr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      add_bin <= in_bin;
      add_bkt <= in_bkt;
      add_w   <= weight;
      idx     <= TOP_BIN;
      k       <= '0;
    end
    if (state == S_PQ_MUL) begin
      need    <= NEED_W'(pm_gap) * NEED_W'(total);
      skipped <= rd_eff;
    end
    if (state == S_PQ_CMP && !pct_done) begin
      idx <= idx - 1'b1;
    end
    if (state == S_PQ_ACC) begin
      skipped <= sat_add(skipped, rd_eff);
    end
    if (state == S_BR_MUL) begin
      rem    <= bkt_prod[PROD_W-1:SW];
      num_lo <= bkt_prod[SW-1:0];
      dstep  <= '0;
    end
    if (state == S_BR_DIV) begin
      rem    <= step_rem;
      num_lo <= num_lo << 1;
      quot   <= {quot[SW-2:0], step_ge};
      dstep  <= dstep + 1'b1;
    end
    if (pct_empty || pct_done) begin
      percentile_bin <= pct_done ? 7'(idx) : '0;
      bucket_index   <= '0;
      bucket_share   <= '0;
      last           <= 1'b1;
    end
    if (bkt_empty || div_done) begin
      percentile_bin <= '0;
      bucket_index   <= 3'(k);
      bucket_share   <= div_done ? {quot[SW-2:0], step_ge} : '0;
      last           <= bkt_last;
      k              <= k + 1'b1;
    end
  end

endmodule

### rtl/whp_checker.sv
module whp_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action,
  input logic        result_strobe,
  input logic [6:0]  percentile_bin,
  input logic [2:0]  bucket_index,
  input logic [13:0] bucket_share,
  input logic        last
);

  assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy)
    else $error("more results pending but block reports idle");

  assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (percentile_bin == 7'd0) || (bucket_index == 3'd0 &&
                      bucket_share == 14'd0))
    else $error("result word mixes query and report fields");

  assert property (@(posedge clk) disable iff (rst)
    result_strobe && percentile_bin != 7'd0 |-> last)
    else $error("percentile word not marked last");

  assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> bucket_share <= 14'd10000)
    else $error("bucket share above full scale");

  assert property (@(posedge clk) disable iff (rst)
    !rst && start && !busy && action == whp_pkg::ACT_ADD |=> busy && !result_strobe)
    else $error("add word not held for write back");

endmodule

bind weighted_histogram_percentile_core whp_checker u_whp_checker (.*);
